// ===== rtl/fspu_pkg.sv =====
// Package for the frame signal pack/unpack unit.
// Holds command codes, fixed field widths and the result bundle type.
// No dependencies.
package fspu_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 64;

    localparam int CMD_W      = 3;
    localparam int BIDX_W     = 6;
    localparam int START_W    = 9;
    localparam int LEN_W      = 7;
    localparam int CFG_LEN_W  = 7;
    localparam int FIELD_W    = 64;
    // bit positions plus a field length, up to 511 + 127
    localparam int POS_W      = 10;

    localparam logic [CFG_LEN_W-1:0] FRAME_LEN_RESET = 7'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 3'd0,
        CMD_WRITE_BYTE = 3'd1,
        CMD_READ_BYTE  = 3'd2,
        CMD_PACK       = 3'd3,
        CMD_UNPACK     = 3'd4
    } fspu_cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0] field_value;
        logic [7:0]         byte_out;
        logic               status;
    } fspu_result_t;

endpackage

// ===== rtl/fspu_field_unit.sv =====
// Single-pass datapath: byte access and signal field insert/extract on the frame image.
// Depends on fspu_pkg.
module fspu_field_unit
    import fspu_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
)
(
    input  logic [8*MAX_FRAME_BYTES-1:0] frame,
    input  logic [CFG_LEN_W-1:0]         frame_length_bytes,
    input  logic [CMD_W-1:0]             cmd,
    input  logic [BIDX_W-1:0]            byte_index,
    input  logic [7:0]                   byte_value,
    input  logic [START_W-1:0]           field_start,
    input  logic [LEN_W-1:0]             field_len,
    input  logic                         motorola_order,
    input  logic                         is_signed,
    input  logic [FIELD_W-1:0]           raw_data,
    output logic [8*MAX_FRAME_BYTES-1:0] frame_new,
    output logic                         frame_we,
    output fspu_result_t                 result
);

    localparam int FRAME_W = 8 * MAX_FRAME_BYTES;
    localparam int IDX_W   = $clog2(MAX_FRAME_BYTES);

    logic [CFG_LEN_W-1:0] eff_len;
    logic [POS_W-1:0]     nbits;
    logic                 len_ok;
    logic                 byte_ok;
    logic                 fits;
    logic [POS_W-1:0]     moto_msb;
    logic [POS_W-1:0]     len_ext;
    logic [POS_W-1:0]     end_pos;
    logic [POS_W-1:0]     shamt;
    logic [IDX_W-1:0]     bidx;
    logic [FIELD_W-1:0]   len_mask;
    logic [FIELD_W-1:0]   extracted;
    logic [FIELD_W-1:0]   unpacked;
    logic [5:0]           top_bit;
    logic [FRAME_W-1:0]   view;
    logic [FRAME_W-1:0]   ins_mask;
    logic [FRAME_W-1:0]   ins_data;
    logic [FRAME_W-1:0]   view_packed;
    logic [FRAME_W-1:0]   frame_packed;
    logic [FRAME_W-1:0]   frame_wbyte;

    // Motorola fields are handled as Intel fields on the byte-reversed frame:
    // the sawtooth becomes a plain ascending run there.
    always_comb
    begin
        for (int b = 0; b < MAX_FRAME_BYTES; b++)
        begin
            view[8*b +: 8] = motorola_order ? frame[8*(MAX_FRAME_BYTES-1-b) +: 8]
                                            : frame[8*b +: 8];
        end
    end

    always_comb
    begin
        for (int b = 0; b < MAX_FRAME_BYTES; b++)
        begin
            frame_packed[8*b +: 8] = motorola_order ?
                                     view_packed[8*(MAX_FRAME_BYTES-1-b) +: 8]
                                                    : view_packed[8*b +: 8];
        end
    end

    assign eff_len  = (frame_length_bytes > CFG_LEN_W'(MAX_FRAME_BYTES)) ?
                      CFG_LEN_W'(MAX_FRAME_BYTES) : frame_length_bytes;
    assign nbits    = {eff_len, 3'b000};
    assign len_ok   = (field_len != '0) && (field_len <= LEN_W'(FIELD_W));
    assign byte_ok  = {1'b0, byte_index} < eff_len;
    assign bidx     = byte_index[IDX_W-1:0];

    // big-endian linear index of the MSB: bit-in-byte mirrored
    assign moto_msb = {1'b0, field_start[8:3], ~field_start[2:0]};
    assign len_ext  = POS_W'(field_len);
    assign end_pos  = (motorola_order ? moto_msb : POS_W'(field_start)) + len_ext;
    assign fits     = len_ok && (end_pos <= nbits);
    assign shamt    = motorola_order ? (POS_W'(FRAME_W) - moto_msb - len_ext)
                                     : POS_W'(field_start);

    assign len_mask = (field_len >= LEN_W'(FIELD_W)) ? '1
                    : ((FIELD_W'(1) << field_len) - FIELD_W'(1));

    assign extracted = FIELD_W'(view >> shamt) & len_mask;
    assign top_bit   = 6'(field_len - LEN_W'(1));
    assign unpacked  = (is_signed && extracted[top_bit]) ? (extracted | ~len_mask)
                                                          : extracted;

    assign ins_mask    = FRAME_W'(len_mask) << shamt;
    assign ins_data    = FRAME_W'(raw_data & len_mask) << shamt;
    assign view_packed = (view & ~ins_mask) | ins_data;

    always_comb
    begin
        frame_wbyte = frame;
        frame_wbyte[{bidx, 3'b000} +: 8] = byte_value;
    end

    always_comb
    begin
        frame_new          = frame;
        frame_we           = 1'b0;
        result.field_value = '0;
        result.byte_out    = '0;
        result.status      = 1'b0;
        case (cmd)
            CMD_CLEAR:
            begin
                frame_new = '0;
                frame_we  = 1'b1;
            end
            CMD_WRITE_BYTE:
            begin
                frame_new     = frame_wbyte;
                frame_we      = byte_ok;
                result.status = !byte_ok;
            end
            CMD_READ_BYTE:
            begin
                result.byte_out = byte_ok ? frame[{bidx, 3'b000} +: 8] : 8'h00;
                result.status   = !byte_ok;
            end
            CMD_PACK:
            begin
                frame_new     = frame_packed;
                frame_we      = fits;
                result.status = !fits;
            end
            CMD_UNPACK:
            begin
                result.field_value = fits ? unpacked : '0;
                result.status      = !fits;
            end
            default:
            begin
                frame_we = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/frame_signal_pack_unpack_unit.sv =====
// Top level of the frame signal pack/unpack unit: handshakes, frame register, result register.
// Depends on fspu_pkg and fspu_field_unit.
//
// Holds one CAN / CAN FD frame image (up to MAX_FRAME_BYTES bytes, in flip-flops) and runs one
// command per transaction: clear, write byte, read byte, pack a raw field, unpack a field
// (zero- or sign-extended to 64 bits), in Intel or Motorola (DBC sawtooth) bit order. Commands
// touching bits or bytes at or beyond frame_length_bytes report status 1 and change nothing.
// Throughput is one transaction per clock unless result_stall holds the output. Each transaction
// goes into one input register; a single shift-and-mask pass then updates the frame and result
// registers. frame_length_bytes resets to 8; the user writes it through the cfg channel while the
// unit is idle (not enforced by the block). The frame resets to all zero with no clearing pass.
module frame_signal_pack_unpack_unit
    import fspu_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_LEN_W-1:0] cfg_data,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [BIDX_W-1:0]    byte_index,
    input  logic [7:0]           byte_value,
    input  logic [START_W-1:0]   field_start,
    input  logic [LEN_W-1:0]     field_len,
    input  logic                 motorola_order,
    input  logic                 is_signed,
    input  logic [FIELD_W-1:0]   raw_data,

    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [FIELD_W-1:0]   field_value,
    output logic [7:0]           byte_out,
    output logic                 status
);

    localparam int FRAME_W = 8 * MAX_FRAME_BYTES;

    logic [FRAME_W-1:0]   frame_reg;
    logic [CFG_LEN_W-1:0] frame_len_reg;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [BIDX_W-1:0]    byte_index_reg;
    logic [7:0]           byte_value_reg;
    logic [START_W-1:0]   field_start_reg;
    logic [LEN_W-1:0]     field_len_reg;
    logic                 motorola_reg;
    logic                 is_signed_reg;
    logic [FIELD_W-1:0]   raw_data_reg;

    logic                 result_valid_reg;
    logic                 result_valid_next;
    fspu_result_t         result_reg;

    logic                 advance;
    logic                 item_accept;
    logic                 s1_fire;

    logic [FRAME_W-1:0]   frame_new;
    logic                 frame_we;
    fspu_result_t         pass_result;

    assign advance     = !result_valid_reg || !result_stall;
    assign s1_fire     = s1_valid_reg && advance;
    assign item_stall  = s1_valid_reg && !advance;
    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        result_valid_next = advance ? s1_valid_reg : result_valid_reg;
    end

    fspu_field_unit #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_field_unit (
        .frame              (frame_reg),
        .frame_length_bytes (frame_len_reg),
        .cmd                (cmd_reg),
        .byte_index         (byte_index_reg),
        .byte_value         (byte_value_reg),
        .field_start        (field_start_reg),
        .field_len          (field_len_reg),
        .motorola_order     (motorola_reg),
        .is_signed          (is_signed_reg),
        .raw_data           (raw_data_reg),
        .frame_new          (frame_new),
        .frame_we           (frame_we),
        .result             (pass_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            frame_len_reg    <= FRAME_LEN_RESET;
            frame_reg        <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                frame_len_reg <= cfg_data;
            end
            if (s1_fire && frame_we)
            begin
                frame_reg <= frame_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            cmd_reg         <= cmd;
            byte_index_reg  <= byte_index;
            byte_value_reg  <= byte_value;
            field_start_reg <= field_start;
            field_len_reg   <= field_len;
            motorola_reg    <= motorola_order;
            is_signed_reg   <= is_signed;
            raw_data_reg    <= raw_data;
        end
        if (s1_fire)
        begin
            result_reg <= pass_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign field_value  = result_reg.field_value;
    assign byte_out     = result_reg.byte_out;
    assign status       = result_reg.status;

    // frame changes only as the effect of a processed transaction
    a_frame_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(frame_reg))
        else $error("frame changed without a processed transaction");

    // a rejected command returns all-zero data
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> (field_value == '0 && byte_out == 8'h00))
        else $error("rejected command returned nonzero data");

    // input side only stalls with a transaction held in the input register
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid_reg))
        else $error("input stalled with nothing pending");

endmodule
